[design/bpa_pkg.sv]
// Shared types, constants and codes for the buddy page allocator.
package bpa_pkg;

	localparam int DEF_PAGE_COUNT = 65536;
	localparam int DEF_MAX_ORDER  = 10;
	localparam int DEF_PAGE_BYTES = 4096;

	localparam int ORD_W = 4;
	localparam logic [ORD_W-1:0] ORDER_NONE = 4'hF;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_NO_SPACE  = 2'd2;
	localparam logic [1:0] ST_BAD_FREE  = 2'd3;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_DEC, S_A_UNL, S_SPL, S_SPL2, S_F_CHK,
		S_MRG, S_BCK, S_UNL, S_PUSH1, S_PUSH2, S_RES
	} state_t;

	typedef enum logic [3:0] {
		OP_NOP, OP_CLR, OP_LOAD, OP_A_START, OP_A_UNL, OP_SPL1, OP_SPL2,
		OP_F_START, OP_F_CHK, OP_F_RDB, OP_F_LATCH, OP_F_UNL,
		OP_PUSH1, OP_PUSH2, OP_RES
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] code;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_free;
		logic oversize;
		logic none_free;
		logic bad_free;
		logic chk_ok;
		logic split_more;
		logic merge_try;
		logic buddy_ok;
		logic out_busy;
	} dp_stat_t;

endpackage

[design/bpa_datapath.sv]
// Page tables, free-list heads, address arithmetic and result register.
module bpa_datapath #(
	parameter int PAGE_COUNT = bpa_pkg::DEF_PAGE_COUNT,
	parameter int MAX_ORDER  = bpa_pkg::DEF_MAX_ORDER,
	parameter int PAGE_BYTES = bpa_pkg::DEF_PAGE_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bpa_pkg::dp_cmd_t   cmd,
	output bpa_pkg::dp_stat_t  stat,
	input  logic               in_command,
	input  logic [22:0]        in_size,
	input  logic [31:0]        in_address,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_value,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [31:0]        out_address,
	output logic [1:0]         out_status
);
	import bpa_pkg::*;

	localparam int PW     = $clog2(PAGE_COUNT);
	localparam int LW     = $clog2(PAGE_COUNT + 1);
	localparam int OW     = $clog2(MAX_ORDER + 1);
	localparam int PBL    = $clog2(PAGE_BYTES);
	localparam int BLOCKS = PAGE_COUNT >> MAX_ORDER;
	localparam int HSTEP  = 1 << MAX_ORDER;
	localparam logic [LW-1:0] NONE_L = LW'(PAGE_COUNT);

	logic [ORD_W:0] info_mem [PAGE_COUNT];
	logic [LW-1:0]  next_mem [PAGE_COUNT];
	logic [LW-1:0]  prev_mem [PAGE_COUNT];

	logic [ORD_W:0] info_rd_q;
	logic [LW-1:0]  next_rd_q, prev_rd_q;

	logic           info_we, next_we, prev_we;
	logic [PW-1:0]  info_wa, next_wa, prev_wa, rd_addr;
	logic [ORD_W:0] info_wd;
	logic [LW-1:0]  next_wd, prev_wd;

	logic [LW-1:0]  heads_q [MAX_ORDER+1];
	logic [PW-1:0]  clr_q, page_q, buddy_q;
	logic [OW-1:0]  ord_q, want_q;
	logic [LW-1:0]  p_q, n_q;
	logic           cmd_q;
	logic [22:0]    size_q;
	logic [31:0]    addr_q, base_q;

	logic [OW-1:0]  want, have, o_dn;
	logic           found;
	logic [31:0]    size32, off, buddy32, c32, blk;
	logic [PW-1:0]  pg, half;
	logic [LW-1:0]  h_spl, h_ord;
	logic           init_head;

	// size rounding and free-list search
	always_comb begin
		size32 = 32'(size_q);
		want   = OW'(MAX_ORDER);
		for (int k = MAX_ORDER; k >= 0; k--) begin
			if (size32 <= (32'(PAGE_BYTES) << k)) want = OW'(k);
		end
		have  = want;
		found = 1'b0;
		for (int k = MAX_ORDER; k >= 0; k--) begin
			if (k >= int'(want) && heads_q[k] != NONE_L) begin
				have  = OW'(k);
				found = 1'b1;
			end
		end
	end

	always_comb begin
		off     = addr_q - base_q;
		pg      = PW'(off >> PBL);
		buddy32 = 32'(page_q) ^ (32'd1 << ord_q);
		o_dn    = ord_q - OW'(1);
		half    = PW'(32'(page_q) + (32'd1 << o_dn));
		h_spl   = heads_q[o_dn];
		h_ord   = heads_q[ord_q];
		c32     = 32'(clr_q);
		blk     = c32 >> MAX_ORDER;
		init_head = ((c32 & 32'(HSTEP - 1)) == 32'd0) && (blk < 32'(BLOCKS));
	end

	always_comb begin
		stat.clr_last   = (clr_q == PW'(PAGE_COUNT - 1));
		stat.is_free    = cmd_q;
		stat.oversize   = size32 > (32'(PAGE_BYTES) << MAX_ORDER);
		stat.none_free  = !found;
		stat.bad_free   = ((off & 32'(PAGE_BYTES - 1)) != 32'd0) ||
		                  ((off >> PBL) >= 32'(PAGE_COUNT));
		stat.chk_ok     = info_rd_q[ORD_W] &&
		                  (info_rd_q[ORD_W-1:0] <= ORD_W'(MAX_ORDER));
		stat.split_more = ord_q > want_q;
		stat.merge_try  = (ord_q < OW'(MAX_ORDER)) && (buddy32 < 32'(PAGE_COUNT));
		stat.buddy_ok   = !info_rd_q[ORD_W] &&
		                  (info_rd_q[ORD_W-1:0] == ORD_W'(ord_q));
		stat.out_busy   = out_valid && !out_ready;
	end

	// memory port selection per micro-op
	always_comb begin
		info_we = 1'b0; info_wa = '0; info_wd = '0;
		next_we = 1'b0; next_wa = '0; next_wd = '0;
		prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
		rd_addr = '0;
		case (cmd.op)
			OP_CLR: begin
				info_we = 1'b1; info_wa = clr_q;
				info_wd = {1'b0, init_head ? ORD_W'(MAX_ORDER) : ORDER_NONE};
				next_we = 1'b1; next_wa = clr_q;
				next_wd = (init_head && blk != 32'd0) ? LW'(c32 - 32'(HSTEP)) : NONE_L;
				prev_we = 1'b1; prev_wa = clr_q;
				prev_wd = (init_head && blk != 32'(BLOCKS - 1)) ?
				          LW'(c32 + 32'(HSTEP)) : NONE_L;
			end
			OP_A_START: rd_addr = heads_q[have][PW-1:0];
			OP_A_UNL: begin
				info_we = 1'b1; info_wa = page_q; info_wd = {1'b1, ORD_W'(want_q)};
				next_we = 1'b1; next_wa = page_q; next_wd = NONE_L;
				prev_we = (next_rd_q != NONE_L);
				prev_wa = next_rd_q[PW-1:0]; prev_wd = NONE_L;
			end
			OP_SPL1: begin
				info_we = 1'b1; info_wa = half; info_wd = {1'b0, ORD_W'(o_dn)};
				next_we = 1'b1; next_wa = half; next_wd = h_spl;
				prev_we = 1'b1; prev_wa = half; prev_wd = NONE_L;
			end
			OP_SPL2: begin
				prev_we = (h_spl != NONE_L);
				prev_wa = h_spl[PW-1:0]; prev_wd = LW'(half);
			end
			OP_F_START: rd_addr = pg;
			OP_F_RDB:   rd_addr = PW'(buddy32);
			OP_F_UNL: begin
				next_we = (p_q != NONE_L); next_wa = p_q[PW-1:0]; next_wd = n_q;
				prev_we = (n_q != NONE_L); prev_wa = n_q[PW-1:0]; prev_wd = p_q;
				info_we = 1'b1; info_wd = {1'b0, ORDER_NONE};
				info_wa = (buddy_q > page_q) ? buddy_q : page_q;
			end
			OP_PUSH1: begin
				info_we = 1'b1; info_wa = page_q; info_wd = {1'b0, ORD_W'(ord_q)};
				next_we = 1'b1; next_wa = page_q; next_wd = h_ord;
				prev_we = 1'b1; prev_wa = page_q; prev_wd = NONE_L;
			end
			OP_PUSH2: begin
				prev_we = (h_ord != NONE_L);
				prev_wa = h_ord[PW-1:0]; prev_wd = LW'(page_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (info_we) info_mem[info_wa] <= info_wd;
		info_rd_q <= info_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_wa] <= next_wd;
		next_rd_q <= next_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		prev_rd_q <= prev_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= MAX_ORDER; k++)
				heads_q[k] <= (k == MAX_ORDER && BLOCKS > 0) ?
				              LW'((BLOCKS - 1) << MAX_ORDER) : NONE_L;
			clr_q       <= '0;
			base_q      <= '0;
			out_valid   <= 1'b0;
			out_status  <= '0;
			out_address <= '0;
			cmd_q       <= 1'b0;
			size_q      <= '0;
			addr_q      <= '0;
			page_q      <= '0;
			ord_q       <= '0;
			want_q      <= '0;
			p_q         <= '0;
			n_q         <= '0;
			buddy_q     <= '0;
		end else begin
			if (cfg_we) base_q <= cfg_value;
			if (out_valid && out_ready && cmd.op != OP_RES) out_valid <= 1'b0;
			case (cmd.op)
				OP_CLR: clr_q <= clr_q + PW'(1);
				OP_LOAD: begin
					cmd_q  <= in_command;
					size_q <= in_size;
					addr_q <= in_address;
				end
				OP_A_START: begin
					page_q <= heads_q[have][PW-1:0];
					ord_q  <= have;
					want_q <= want;
				end
				OP_A_UNL: heads_q[ord_q] <= next_rd_q;
				OP_SPL2: begin
					heads_q[o_dn] <= LW'(half);
					ord_q         <= o_dn;
				end
				OP_F_START: page_q <= pg;
				OP_F_CHK:   ord_q  <= OW'(info_rd_q[ORD_W-1:0]);
				OP_F_LATCH: begin
					p_q     <= prev_rd_q;
					n_q     <= next_rd_q;
					buddy_q <= PW'(buddy32);
				end
				OP_F_UNL: begin
					if (p_q == NONE_L) heads_q[ord_q] <= n_q;
					if (buddy_q < page_q) page_q <= buddy_q;
					ord_q <= ord_q + OW'(1);
				end
				OP_PUSH2: heads_q[ord_q] <= LW'(page_q);
				OP_RES: begin
					out_valid   <= 1'b1;
					out_status  <= cmd.code;
					out_address <= (cmd.code == ST_OK && !cmd_q) ?
					               base_q + (32'(page_q) << PBL) : 32'd0;
				end
				default: ;
			endcase
		end
	end

endmodule

[design/bpa_ctrl.sv]
// Sequencer for clearing, allocation splits and free merges.
module bpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bpa_pkg::dp_stat_t  stat,
	output bpa_pkg::dp_cmd_t   cmd
);
	import bpa_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			code_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		code_d   = code_q;
		in_ready = 1'b0;
		cmd.op   = OP_NOP;
		cmd.code = code_q;
		case (state_q)
			S_INIT: begin
				cmd.op = OP_CLR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (stat.is_free) begin
					if (stat.bad_free) begin
						code_d = ST_BAD_FREE; state_d = S_RES;
					end else begin
						cmd.op = OP_F_START; state_d = S_F_CHK;
					end
				end else if (stat.oversize) begin
					code_d = ST_TOO_LARGE; state_d = S_RES;
				end else if (stat.none_free) begin
					code_d = ST_NO_SPACE; state_d = S_RES;
				end else begin
					cmd.op = OP_A_START; state_d = S_A_UNL;
				end
			end
			S_A_UNL: begin
				cmd.op  = OP_A_UNL;
				state_d = S_SPL;
			end
			S_SPL: begin
				if (stat.split_more) begin
					cmd.op = OP_SPL1; state_d = S_SPL2;
				end else begin
					code_d = ST_OK; state_d = S_RES;
				end
			end
			S_SPL2: begin
				cmd.op  = OP_SPL2;
				state_d = S_SPL;
			end
			S_F_CHK: begin
				if (stat.chk_ok) begin
					cmd.op = OP_F_CHK; state_d = S_MRG;
				end else begin
					code_d = ST_BAD_FREE; state_d = S_RES;
				end
			end
			S_MRG: begin
				if (stat.merge_try) begin
					cmd.op = OP_F_RDB; state_d = S_BCK;
				end else begin
					state_d = S_PUSH1;
				end
			end
			S_BCK: begin
				if (stat.buddy_ok) begin
					cmd.op = OP_F_LATCH; state_d = S_UNL;
				end else begin
					state_d = S_PUSH1;
				end
			end
			S_UNL: begin
				cmd.op  = OP_F_UNL;
				state_d = S_MRG;
			end
			S_PUSH1: begin
				cmd.op  = OP_PUSH1;
				state_d = S_PUSH2;
			end
			S_PUSH2: begin
				cmd.op  = OP_PUSH2;
				code_d  = ST_OK;
				state_d = S_RES;
			end
			S_RES: begin
				if (!stat.out_busy) begin
					cmd.op  = OP_RES;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[design/buddy_page_allocator_top.sv]
// Buddy page allocator: top level joining sequencer and datapath.
// After reset a clearing pass writes one page entry per cycle, one for every page, and
// accepts no item until it is done (configuration writes are taken throughout).
// Alloc unlinks a block and splits it down; free checks the page, merges free buddies, pushes.
// Rejects go to the result once found: one page-table access a cycle, plus output stalls.
// One item at a time. Reset is asynchronous, active low; base_address resets to zero.
module buddy_page_allocator_top #(
	parameter int PAGE_COUNT = bpa_pkg::DEF_PAGE_COUNT,
	parameter int MAX_ORDER  = bpa_pkg::DEF_MAX_ORDER,
	parameter int PAGE_BYTES = bpa_pkg::DEF_PAGE_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,      // base_address
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // size_bytes[22:0], address[54:23], zero pad
	input  logic [0:0]  s_axis_tuser,  // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // block_address
	output logic [1:0]  m_axis_tuser   // status
);
	import bpa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bpa_datapath #(
		.PAGE_COUNT (PAGE_COUNT),
		.MAX_ORDER  (MAX_ORDER),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_command  (s_axis_tuser[0]),
		.in_size     (s_axis_tdata[22:0]),
		.in_address  (s_axis_tdata[54:23]),
		.cfg_we      (cfg_valid),
		.cfg_value   (cfg_data),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_address (m_axis_tdata),
		.out_status  (m_axis_tuser)
	);

endmodule
